FILE: design/ofr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofr_pkg
// Types and constants shared by the oversampled frame receiver and its
// channel interfaces.
// ----------------------------------------------------------------------------
package ofr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SAMPLE_W   = 10;
    localparam int TICK_W     = 16;
    localparam int MSG_W      = 4;
    localparam int PATTERN_W  = 8;
    localparam int BYTE_W     = 8;
    localparam int POSTFIX_BITS = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_THRESHOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX_PATTERN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POSTFIX_PATTERN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_LIMIT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OVERTIME_LIMIT   = 3'd6;

    localparam logic [SAMPLE_W-1:0]  RST_SAMPLES_PER_BIT  = 10'd100;
    localparam logic [SAMPLE_W-1:0]  RST_PREFIX_THRESHOLD = 10'd90;
    localparam logic [SAMPLE_W-1:0]  RST_DATA_THRESHOLD   = 10'd70;
    localparam logic [PATTERN_W-1:0] RST_PREFIX_PATTERN   = 8'hFF;
    localparam logic [PATTERN_W-1:0] RST_POSTFIX_PATTERN  = 8'h01;
    localparam logic [MSG_W-1:0]     RST_MESSAGE_LIMIT    = 4'd2;
    localparam logic [TICK_W-1:0]    RST_OVERTIME_LIMIT   = 16'd8105;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_POST = 2'd2;

    typedef struct packed {
        logic line_sample;
    } t_in_item;

    typedef struct packed {
        logic              prefix_seen;
        logic              frame_done;
        logic [BYTE_W-1:0] data_byte;
        logic              parity_ok;
        logic              postfix_ok;
        logic              sleep_request;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_item;

endpackage

FILE: design/ofr_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofr_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface ofr_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/oversampled_frame_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oversampled_frame_receiver_core
// Oversampled serial frame receiver: bit decision by ones count, prefix hunt,
// data plus even parity capture, postfix check and sleep request.
// The input register holds each accepted sample until it advances into the result register.
// Throughput: one item per cycle while results drain, a held result stalls input;
// all per-item work is counter updates and threshold compares.
// Items causing no result are consumed without output.
// Reset: synchronous, clears counters and phase, loads register defaults.
// ----------------------------------------------------------------------------
module oversampled_frame_receiver_core #(
    parameter int DATA_BITS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ofr_stream_if.sink   i_in,
    ofr_stream_if.source o_out,
    ofr_stream_if.sink   i_cfg
);
    import ofr_pkg::*;

    localparam int FRAME_W = DATA_BITS + 1;
    localparam int SHIFT_W = (FRAME_W > PATTERN_W) ? FRAME_W : PATTERN_W;
    localparam int IDX_W   = $clog2(SHIFT_W + 1);

    // configuration registers
    logic [SAMPLE_W-1:0]  r_samples_per_bit;
    logic [SAMPLE_W-1:0]  r_prefix_threshold;
    logic [SAMPLE_W-1:0]  r_data_threshold;
    logic [PATTERN_W-1:0] r_prefix_pattern;
    logic [PATTERN_W-1:0] r_postfix_pattern;
    logic [MSG_W-1:0]     r_message_limit;
    logic [TICK_W-1:0]    r_overtime_limit;

    // receiver state
    logic [SAMPLE_W-1:0] r_sample_count, n_sample_count;
    logic [SAMPLE_W-1:0] r_ones_count, n_ones_count;
    logic [SHIFT_W-1:0]  r_bit_shift, n_bit_shift;
    logic [IDX_W-1:0]    r_bit_index, n_bit_index;
    logic [1:0]          r_phase, n_phase;
    logic [FRAME_W-1:0]  r_captured, n_captured;
    logic [MSG_W-1:0]    r_message_count, n_message_count;
    logic [TICK_W-1:0]   r_tick_count, n_tick_count;

    // pipeline registers
    logic      r_in_valid;
    logic      r_in_sample;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      n_has_result;
    logic      w_advance;

    logic [SAMPLE_W-1:0]   w_samp_inc;
    logic [SAMPLE_W-1:0]   w_ones_inc;
    logic [TICK_W-1:0]     w_tick_inc;
    logic [SAMPLE_W-1:0]   w_thr;
    logic                  w_hunting;
    logic                  w_bit;
    logic [SHIFT_W-1:0]    w_shifted;
    logic [IDX_W-1:0]      w_idx_inc;
    logic [FRAME_W+7:0]    w_cap_ext;

    assign w_advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_advance;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;
    assign i_cfg.ready = 1'b1;

    // per-item datapath
    assign w_tick_inc = (r_tick_count == {TICK_W{1'b1}}) ? r_tick_count
                                                         : r_tick_count + 1'b1;
    assign w_ones_inc = (r_in_sample && r_ones_count != {SAMPLE_W{1'b1}})
                        ? r_ones_count + 1'b1 : r_ones_count;
    assign w_samp_inc = r_sample_count + 1'b1;
    assign w_hunting  = (r_phase != PH_DATA) && (r_phase != PH_POST);
    assign w_thr      = w_hunting ? r_prefix_threshold : r_data_threshold;
    assign w_bit      = (w_ones_inc >= w_thr);
    assign w_shifted  = {r_bit_shift[SHIFT_W-2:0], w_bit};
    assign w_idx_inc  = r_bit_index + 1'b1;
    assign w_cap_ext  = {{BYTE_W{1'b0}}, r_captured};

    always_comb begin
        n_sample_count  = w_samp_inc;
        n_ones_count    = w_ones_inc;
        n_bit_shift     = r_bit_shift;
        n_bit_index     = r_bit_index;
        n_phase         = r_phase;
        n_captured      = r_captured;
        n_message_count = r_message_count;
        n_tick_count    = w_tick_inc;
        n_out           = '0;

        if (w_samp_inc == r_samples_per_bit) begin
            n_sample_count = '0;
            n_ones_count   = '0;
            n_bit_shift    = w_shifted;
            unique case (r_phase)
                PH_DATA: begin
                    n_bit_index = w_idx_inc;
                    if (w_idx_inc >= IDX_W'(FRAME_W)) begin
                        n_captured  = w_shifted[FRAME_W-1:0];
                        n_bit_shift = '0;
                        n_bit_index = '0;
                        n_phase     = PH_POST;
                    end
                end
                PH_POST: begin
                    n_bit_index = w_idx_inc;
                    if (w_idx_inc >= IDX_W'(POSTFIX_BITS)) begin
                        n_out.frame_done = 1'b1;
                        n_out.data_byte  = w_cap_ext[BYTE_W:1];
                        n_out.parity_ok  = ~(^r_captured);
                        n_out.postfix_ok = (w_shifted == SHIFT_W'(r_postfix_pattern));
                        n_bit_index      = '0;
                        n_phase          = PH_HUNT;
                        if (r_message_count != {MSG_W{1'b1}}) begin
                            n_message_count = r_message_count + 1'b1;
                        end
                    end
                end
                default: begin
                    n_bit_index = '0;
                    if ((w_shifted[PATTERN_W-1:0] & r_prefix_pattern) == r_prefix_pattern) begin
                        n_bit_shift       = '0;
                        n_phase           = PH_DATA;
                        n_out.prefix_seen = 1'b1;
                    end
                end
            endcase
        end

        if (n_message_count > r_message_limit || n_tick_count > r_overtime_limit) begin
            n_message_count     = '0;
            n_tick_count        = '0;
            n_out.sleep_request = 1'b1;
        end

        n_has_result = n_out.prefix_seen | n_out.frame_done | n_out.sleep_request;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples_per_bit  <= RST_SAMPLES_PER_BIT;
            r_prefix_threshold <= RST_PREFIX_THRESHOLD;
            r_data_threshold   <= RST_DATA_THRESHOLD;
            r_prefix_pattern   <= RST_PREFIX_PATTERN;
            r_postfix_pattern  <= RST_POSTFIX_PATTERN;
            r_message_limit    <= RST_MESSAGE_LIMIT;
            r_overtime_limit   <= RST_OVERTIME_LIMIT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.payload.index)
                REG_SAMPLES_PER_BIT:  r_samples_per_bit  <= i_cfg.payload.data[SAMPLE_W-1:0];
                REG_PREFIX_THRESHOLD: r_prefix_threshold <= i_cfg.payload.data[SAMPLE_W-1:0];
                REG_DATA_THRESHOLD:   r_data_threshold   <= i_cfg.payload.data[SAMPLE_W-1:0];
                REG_PREFIX_PATTERN:   r_prefix_pattern   <= i_cfg.payload.data[PATTERN_W-1:0];
                REG_POSTFIX_PATTERN:  r_postfix_pattern  <= i_cfg.payload.data[PATTERN_W-1:0];
                REG_MESSAGE_LIMIT:    r_message_limit    <= i_cfg.payload.data[MSG_W-1:0];
                REG_OVERTIME_LIMIT:   r_overtime_limit   <= i_cfg.payload.data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_sample <= i_in.payload.line_sample;
        end
    end

    // receiver state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count  <= '0;
            r_ones_count    <= '0;
            r_bit_shift     <= '0;
            r_bit_index     <= '0;
            r_phase         <= PH_HUNT;
            r_captured      <= '0;
            r_message_count <= '0;
            r_tick_count    <= '0;
        end else if (w_advance) begin
            r_sample_count  <= n_sample_count;
            r_ones_count    <= n_ones_count;
            r_bit_shift     <= n_bit_shift;
            r_bit_index     <= n_bit_index;
            r_phase         <= n_phase;
            r_captured      <= n_captured;
            r_message_count <= n_message_count;
            r_tick_count    <= n_tick_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= n_has_result;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && n_has_result) begin
            r_out <= n_out;
        end
    end

endmodule
